FILE: hw/rtl/rau_pkg.sv
// package for the rational arithmetic unit: types, codes and constants
`default_nettype none
package rau_pkg;
    localparam int unsigned NumWidthDefault = 32;
    localparam int unsigned DenWidthDefault = 32;
    localparam int unsigned MagWidth        = 64;
    localparam int unsigned CntWidth        = 7;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic [63:0] res_num;
        logic [63:0] res_den;
        logic [1:0]  status;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture operands, split signs
        logic mul0;     // first product pair
        logic mul1;     // second product pair
        logic combine;  // sum / sign, set up gcd
        logic div_init; // start one long division
        logic div_step; // one quotient bit
        logic div_sel;  // 0 gcd remainder, 1 reduce numerator/denominator
        logic gcd_next; // move y to x and the remainder into y
        logic red_num;  // store reduced numerator, load denominator as next dividend
        logic finish;   // form output
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic bad;      // zero denominator or divide by zero
        logic zero;     // exact result zero
        logic y_zero;   // gcd remainder is zero
    } t_dp_sts;
endpackage
`default_nettype wire

FILE: hw/rtl/rational_arith_unit.sv
// top level of the rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and returns the
// result in lowest terms with a status (ok, zero denominator, overflow).
// one transaction at a time: the products are formed in the mul0, mul1 and
// combine states, then the gcd runs as repeated shift-subtract remainders
// (one per Euclid step), then two divisions reduce numerator and
// denominator, all on the single one-bit-per-cycle divider in the datapath.
// the result is held in an output register until taken; the next input is
// accepted after that.
`default_nettype none
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int unsigned NUM_WIDTH = NumWidthDefault,
    parameter int unsigned DEN_WIDTH = DenWidthDefault
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);
    t_dp_cmd cmd;   // controller commands
    t_dp_sts sts;   // datapath status

    // sequencer
    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic and shared divider
    rau_datapath #(
        .NUM_WIDTH (NUM_WIDTH),
        .DEN_WIDTH (DEN_WIDTH)
    ) u_dp (
        .i_clk  (i_clk),
        .i_item (i_in_data),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_item (o_out_data)
    );

    // never ready for input while a result is pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // result appears only after the finish command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.finish))
        else $error("result without finish");

    // ok results have a nonzero denominator
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_OK) |-> o_out_data.res_den != '0)
        else $error("ok result with zero denominator");
endmodule
`default_nettype wire

FILE: hw/rtl/rau_datapath.sv
// datapath: operand split, products, gcd and reduction by shift-subtract division
`default_nettype none
module rau_datapath
    import rau_pkg::*;
#(
    parameter int unsigned NUM_WIDTH = NumWidthDefault,
    parameter int unsigned DEN_WIDTH = DenWidthDefault
) (
    input  wire logic      i_clk,
    input  wire t_in_item  i_item,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_sts        o_sts,
    output t_out_item      o_item
);
    logic [31:0] r_am, r_bm, r_ad, r_bd;
    logic        r_an, r_bn, r_rn;
    logic [1:0]  r_act;
    logic [63:0] r_p0, r_p1;
    logic [63:0] r_x, r_y;          // gcd operands
    logic [63:0] r_mag, r_den;      // unreduced result
    logic [63:0] r_rnum;            // reduced numerator
    logic [63:0] r_q, r_rem, r_dvd, r_dvs;
    logic        r_bad, r_zero;
    t_out_item   r_out;

    logic [NUM_WIDTH-1:0] a_raw, b_raw;
    logic [DEN_WIDTH-1:0] ad_raw, bd_raw;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic [63:0] sum;
    logic        sum_neg;

    assign a_raw  = i_item.a_num[NUM_WIDTH-1:0];
    assign b_raw  = i_item.b_num[NUM_WIDTH-1:0];
    assign ad_raw = i_item.a_den[DEN_WIDTH-1:0];
    assign bd_raw = i_item.b_den[DEN_WIDTH-1:0];

    assign rem_sh  = {r_rem, r_dvd[63]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_comb begin
        logic n2;
        n2 = (r_act == ACT_SUB) ? ~r_bn : r_bn;
        if (r_act == ACT_MUL || r_act == ACT_DIV) begin
            sum     = r_p0;
            sum_neg = r_an ^ r_bn;
        end else if (r_an == n2) begin
            sum     = r_p0 + r_p1;
            sum_neg = r_an;
        end else if (r_p0 >= r_p1) begin
            sum     = r_p0 - r_p1;
            sum_neg = r_an;
        end else begin
            sum     = r_p1 - r_p0;
            sum_neg = n2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_item.action;
            r_an  <= a_raw[NUM_WIDTH-1];
            r_bn  <= b_raw[NUM_WIDTH-1];
            r_am  <= 32'(a_raw[NUM_WIDTH-1] ? (~a_raw + 1'b1) : a_raw);
            r_bm  <= 32'(b_raw[NUM_WIDTH-1] ? (~b_raw + 1'b1) : b_raw);
            r_ad  <= 32'(ad_raw);
            r_bd  <= 32'(bd_raw);
            r_bad <= (ad_raw == '0) || (bd_raw == '0)
                     || (i_item.action == ACT_DIV && b_raw == '0);
        end
        if (i_cmd.mul0) begin
            // numerator term (or product)
            if (r_act == ACT_MUL) r_p0 <= r_am * r_bm;
            else                  r_p0 <= r_am * r_bd;
        end
        if (i_cmd.mul1) begin
            r_p1 <= r_bm * r_ad;
            if (r_act == ACT_DIV) r_den <= r_ad * r_bm;
            else                  r_den <= r_ad * r_bd;
        end
        if (i_cmd.combine) begin
            r_mag  <= sum;
            r_rn   <= sum_neg;
            r_zero <= (sum == '0);
            r_x    <= sum;
            r_y    <= r_den;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_q   <= '0;
            if (!i_cmd.div_sel) begin
                r_dvd <= r_x;
                r_dvs <= r_y;
            end else begin
                r_dvd <= r_mag;
                r_dvs <= r_x;
            end
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            if (!rem_sub[64]) begin
                r_rem <= rem_sub[63:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh[63:0];
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
        if (i_cmd.gcd_next) begin
            // comes with the last quotient bit: take the final remainder
            r_x <= r_y;
            r_y <= rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];
        end
        if (i_cmd.red_num) begin
            r_rnum <= r_q;
            r_mag  <= r_den;   // reuse as next dividend
        end
        if (i_cmd.finish) begin
            if (r_bad) begin
                r_out <= '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
            end else if (r_zero) begin
                r_out <= '{res_num: '0, res_den: 64'd1, status: ST_OK};
            end else if (!r_rn && r_rnum[63]) begin
                r_out <= '{res_num: 64'h7FFF_FFFF_FFFF_FFFF, res_den: r_q,
                           status: ST_OVERFLOW};
            end else if (r_rn && r_rnum > 64'h8000_0000_0000_0000) begin
                r_out <= '{res_num: 64'h8000_0000_0000_0000, res_den: r_q,
                           status: ST_OVERFLOW};
            end else begin
                r_out <= '{res_num: r_rn ? (~r_rnum + 64'd1) : r_rnum,
                           res_den: r_q, status: ST_OK};
            end
        end
    end

    assign o_sts  = '{bad: r_bad, zero: r_zero, y_zero: (r_y == '0)};
    assign o_item = r_out;
endmodule
`default_nettype wire

FILE: hw/rtl/rau_ctrl.sv
// controller: sequences products, gcd remainders and the two reductions
`default_nettype none
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_sts  i_sts,
    output t_dp_cmd       o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL0  = 10'b00_0000_0010,
        S_MUL1  = 10'b00_0000_0100,
        S_COMB  = 10'b00_0000_1000,
        S_GTEST = 10'b00_0001_0000,
        S_GDIV  = 10'b00_0010_0000,
        S_RNUM  = 10'b00_0100_0000,
        S_RDEN  = 10'b00_1000_0000,
        S_FIN   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CntWidth-1:0] r_cnt, n_cnt;
    logic r_pass, n_pass;   // 0 numerator reduction, 1 denominator

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = i_sts.bad ? S_FIN : S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_COMB;
            end
            S_COMB: begin
                o_cmd.combine = 1'b1;
                n_state       = S_GTEST;
            end
            S_GTEST: begin
                if (i_sts.zero) begin
                    n_state = S_FIN;
                end else if (i_sts.y_zero) begin
                    o_cmd.div_init = 1'b1;
                    o_cmd.div_sel  = 1'b1;
                    n_cnt   = '0;
                    n_pass  = 1'b0;
                    n_state = S_RNUM;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt   = '0;
                    n_state = S_GDIV;
                end
            end
            S_GDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CntWidth'(63)) n_state = S_GTEST;
            end
            S_RNUM: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CntWidth'(63)) n_state = S_RDEN;
            end
            S_RDEN: begin
                if (!r_pass) begin
                    o_cmd.red_num = 1'b1;
                    n_pass  = 1'b1;
                    n_state = S_RDEN;
                end else begin
                    o_cmd.div_init = 1'b1;
                    o_cmd.div_sel  = 1'b1;
                    n_cnt   = '0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_pass && !i_sts.bad && !i_sts.zero) begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CntWidth'(63)) n_pass = 1'b0;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_GDIV && r_cnt == CntWidth'(63)) o_cmd.gcd_next = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
        end
    end
endmodule
`default_nettype wire
